### hw/rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and codes for the sorted min-first priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int KEY_W  = 32;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int FILL_W = 5;

  // Request and result word widths, padded to whole bytes.
  localparam int IN_W  = ((CMD_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_W = ((KEY_W + ST_W + FILL_W + 7) / 8) * 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [KEY_W-1:0]  key;
  } smpq_op_t;

endpackage

### hw/rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: holds a key and moves it on insert or pop.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic                       clk,
  input  smpq_pkg::smpq_op_t         op,
  input  logic                       occupied,
  input  logic [smpq_pkg::KEY_W-1:0] left_key,
  input  logic                       left_le,
  input  logic [smpq_pkg::KEY_W-1:0] right_key,
  output logic [smpq_pkg::KEY_W-1:0] key,
  output logic                       le
);

  // This slot keeps its key on insert when it holds a key not above the new one.
  assign le = occupied && ($signed(key) <= $signed(op.key));

  // Insert opens a gap at the first slot above the new key; pop shifts toward the head.
  always_ff @(posedge clk) begin
    if (op.ins && !le) begin
      key <= left_le ? op.key : left_key;
    end else if (op.pop) begin
      key <= right_key;
    end
  end

endmodule

### hw/rtl/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Min-first priority queue of signed 32-bit keys kept in ascending order.
// ----------------------------------------------------------------------------
// Every request (add, pop or peek) gives exactly one result: the keys sit in
// a row of QUEUE_DEPTH cells that all compare against the broadcast key at
// once, so an insert or a pop completes in the cycle the request is accepted,
// and a new request is taken every cycle while the result register is free or
// being drained. Equal keys leave in arrival order. Add on a full queue drops
// the key and reports full; pop or peek on an empty queue reports empty.
// fill_count is the low five bits of the count.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata: command[1:0], key_in[33:2], zero padding above
  input  logic [smpq_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata: key_out[31:0], status[33:32], fill_count[38:34], zero padding above
  output logic [smpq_pkg::OUT_W-1:0] m_tdata
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = smpq_pkg::KEY_W;
  localparam int PAD_W = smpq_pkg::OUT_W - KW - smpq_pkg::ST_W - smpq_pkg::FILL_W;

  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         accept;
  logic [smpq_pkg::CMD_W-1:0]   command;
  logic [KW-1:0]                key_in;
  logic                         full;
  logic                         empty;
  smpq_pkg::smpq_op_t           op;
  logic [KW-1:0]                key_out_next;
  logic [smpq_pkg::ST_W-1:0]    status_next;
  logic [KW-1:0]                key_out;
  logic [smpq_pkg::ST_W-1:0]    status;
  logic [smpq_pkg::FILL_W-1:0]  fill_count;

  logic [KW-1:0]                cell_key [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       cell_le;

  // Request decode.
  assign accept  = s_tvalid && s_tready;
  assign command = s_tdata[smpq_pkg::CMD_W-1:0];
  assign key_in  = s_tdata[smpq_pkg::CMD_W +: KW];
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);

  assign op.ins = accept && (command == smpq_pkg::CMD_ADD) && !full;
  assign op.pop = accept && (command == smpq_pkg::CMD_POP) && !empty;
  assign op.key = key_in;

  // Row of cells; the head holds the smallest key.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KW-1:0] left_key;
    logic          left_le;
    logic [KW-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = key_in;
      assign left_le  = 1'b1;
    end else begin : g_body
      assign left_key = cell_key[i-1];
      assign left_le  = cell_le[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    smpq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .occupied  (CW'(i) < count),
      .left_key  (left_key),
      .left_le   (left_le),
      .right_key (right_key),
      .key       (cell_key[i]),
      .le        (cell_le[i])
    );
  end

  // Result and next count.
  always_comb begin
    key_out_next = '0;
    status_next  = smpq_pkg::ST_OK;
    count_next   = count;
    unique case (command) inside
      smpq_pkg::CMD_ADD: begin
        if (full) begin
          status_next = smpq_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      smpq_pkg::CMD_POP, smpq_pkg::CMD_PEEK: begin
        if (empty) begin
          status_next = smpq_pkg::ST_EMPTY;
        end else begin
          key_out_next = cell_key[0];
          if (command == smpq_pkg::CMD_POP) begin
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Count register and result register.
  assign s_tready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_out    <= key_out_next;
      status     <= status_next;
      fill_count <= smpq_pkg::FILL_W'(32'(count_next));
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, fill_count, status, key_out};

endmodule

### hw/rtl/smpq_checker.sv
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks for the sorted min-first priority queue.
// ----------------------------------------------------------------------------
module smpq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [smpq_pkg::OUT_W-1:0] m_tdata
);

  localparam logic [smpq_pkg::FILL_W-1:0] FULL_FILL = smpq_pkg::FILL_W'(QUEUE_DEPTH);

  logic [smpq_pkg::KEY_W-1:0]  key_out;
  logic [smpq_pkg::ST_W-1:0]   status;
  logic [smpq_pkg::FILL_W-1:0] fill_count;

  assign key_out    = m_tdata[smpq_pkg::KEY_W-1:0];
  assign status     = m_tdata[smpq_pkg::KEY_W +: smpq_pkg::ST_W];
  assign fill_count = m_tdata[smpq_pkg::KEY_W + smpq_pkg::ST_W +: smpq_pkg::FILL_W];

  // A held result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The queue never stalls requests while its result register is empty.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request stalled with no result pending");

  // An empty report carries a zero key and a zero count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == smpq_pkg::ST_EMPTY) |-> (key_out == '0) && (fill_count == '0))
    else $error("empty result with nonzero key or count");

  // A full report carries a zero key and the full count.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == smpq_pkg::ST_FULL) |-> (key_out == '0) && (fill_count == FULL_FILL))
    else $error("full result with wrong key or count");

  // Every accepted request shows its result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result");

endmodule

bind sorted_min_priority_queue smpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_smpq_checker (.*);

### tb/sorted_min_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_tb
// Self-checking testbench for the sorted min-first priority queue.
// ----------------------------------------------------------------------------
// A local model of the queue predicts the key, status and fill count of every
// accepted request. Each result from the block is checked against the oldest
// prediction. Directed requests cover the empty and full queue, the key
// extremes, duplicates and the unused command code. Random traffic then moves
// between add-heavy and pop-heavy mixes, with random gaps on or off per side. One
// test holds off the result side long enough to stall the request side.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QUEUE_DEPTH  = 16;
  localparam realtime     CLK_PERIOD   = 4.0;
  localparam int          RESET_CYCLES = 10;
  localparam int          DRAIN_CYCLES = 32;
  localparam int unsigned RUN_LIMIT    = 200000;
  localparam int          MAX_GAP      = 14;
  localparam int          HOLD_CYCLES  = 150;

  // Command code 3 is not assigned; the block treats it as a no-op.
  localparam logic [smpq_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

  localparam logic [smpq_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [smpq_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

  localparam int KW = smpq_pkg::KEY_W;
  localparam int SW = smpq_pkg::ST_W;
  localparam int FW = smpq_pkg::FILL_W;
  localparam int MW = smpq_pkg::CMD_W;

  typedef struct packed {
    logic [smpq_pkg::KEY_W-1:0]  key;
    logic [smpq_pkg::ST_W-1:0]   status;
    logic [smpq_pkg::FILL_W-1:0] fill;
  } queue_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [smpq_pkg::IN_W-1:0]  s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [smpq_pkg::OUT_W-1:0] m_tdata;

  // Model of the queue contents, kept in ascending order.
  logic [smpq_pkg::KEY_W-1:0] model_keys [QUEUE_DEPTH];
  int                         model_count = 0;
  queue_result_t              pending_results [$];

  // Idle controls for the stimulus and the result sink.
  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_off  = 0;

  int error_count = 0;
  int n_add = 0, n_pop = 0, n_peek = 0, n_nop = 0;
  int n_full = 0, n_empty = 0, n_checked = 0, deepest = 0;

  sorted_min_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Print one line per mismatch and keep count.
  task automatic report_mismatch(input string what, input logic [KW-1:0] got,
                                 input logic [KW-1:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what,
             $signed(got), $signed(want));
  endtask

  // Apply one request to the model and queue the result it must produce.
  task automatic predict_result(input logic [MW-1:0] cmd, input logic [KW-1:0] key);
    queue_result_t res;
    int            pos;
    res = '{key: '0, status: smpq_pkg::ST_OK, fill: '0};
    case (cmd) inside
      smpq_pkg::CMD_ADD: begin
        n_add++;
        if (model_count >= QUEUE_DEPTH) begin
          res.status = smpq_pkg::ST_FULL;
          n_full++;
        end else begin
          // A new key goes behind every key that is less than or equal to it.
          pos = 0;
          while (pos < model_count && $signed(model_keys[pos]) <= $signed(key)) pos++;
          for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = key;
          model_count++;
        end
      end
      smpq_pkg::CMD_POP, smpq_pkg::CMD_PEEK: begin
        if (cmd == smpq_pkg::CMD_POP) n_pop++;
        else n_peek++;
        if (model_count == 0) begin
          res.status = smpq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          res.key = model_keys[0];
          if (cmd == smpq_pkg::CMD_POP) begin
            for (int i = 1; i < model_count; i++) model_keys[i-1] = model_keys[i];
            model_count--;
          end
        end
      end
      default: n_nop++;
    endcase
    if (model_count > deepest) deepest = model_count;
    res.fill = model_count[FW-1:0];
    pending_results.insert(pending_results.size(), res);
  endtask

  // Predict on every accepted request.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_result(s_tdata[MW-1:0], s_tdata[MW+KW-1:MW]);
    end
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", m_tdata[KW-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (m_tdata[KW-1:0] !== want.key) begin
          report_mismatch("key_out", m_tdata[KW-1:0], want.key);
        end
        if (m_tdata[KW+SW-1:KW] !== want.status) begin
          report_mismatch("status", 32'(m_tdata[KW+SW-1:KW]), 32'(want.status));
        end
        if (m_tdata[KW+SW+FW-1:KW+SW] !== want.fill) begin
          report_mismatch("fill_count", 32'(m_tdata[KW+SW+FW-1:KW+SW]),
                          32'(want.fill));
        end
      end
    end
  end

  // Result sink: a random wait before each result, or a long hold-off on request.
  initial begin : result_sink
    int wait_cycles;
    wait (!rst);
    forever begin
      wait_cycles = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_off > 0) begin
        wait_cycles = hold_off;
        hold_off = 0;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles,
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Offer one request after a random gap and wait until it is taken. Valid is
  // left high so that a back-to-back request needs no second assignment.
  task automatic issue_request(input logic [MW-1:0] cmd, input logic [KW-1:0] key);
    int gap;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(smpq_pkg::IN_W - MW - KW){1'b0}}, key, cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  // Half the keys are uniform; the rest are extremes and a narrow band that makes duplicates.
  function automatic logic [KW-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3, 4: return $urandom_range(0, 8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Pop, peek and the no-op code on an empty queue.
  task automatic test_empty_queue();
    issue_request(smpq_pkg::CMD_POP, KEY_MAX);
    issue_request(smpq_pkg::CMD_PEEK, KEY_MIN);
    issue_request(CMD_NOP, 32'hFFFF_FFFF);
  endtask

  // Key extremes, negative and positive values and duplicates, then a peek, the no-op code and a pop.
  task automatic test_key_ordering();
    issue_request(smpq_pkg::CMD_ADD, KEY_MAX);
    issue_request(smpq_pkg::CMD_ADD, KEY_MIN);
    issue_request(smpq_pkg::CMD_ADD, 32'd0);
    issue_request(smpq_pkg::CMD_ADD, 32'hFFFF_FFFF);
    issue_request(smpq_pkg::CMD_ADD, 32'd1);
    issue_request(smpq_pkg::CMD_ADD, 32'd5);
    issue_request(smpq_pkg::CMD_ADD, 32'd5);
    issue_request(smpq_pkg::CMD_ADD, 32'hFFFF_FFFF);
    issue_request(smpq_pkg::CMD_PEEK, 32'd0);
    issue_request(CMD_NOP, 32'h1234_5678);
    issue_request(smpq_pkg::CMD_POP, 32'd0);
  endtask

  // Fill to the last slot, then one add that must be dropped.
  task automatic test_full_queue();
    for (int i = 0; i < 9; i++) issue_request(smpq_pkg::CMD_ADD, pick_key());
    issue_request(smpq_pkg::CMD_ADD, KEY_MIN);
  endtask

  // Random traffic; add_pct steers the queue toward full or toward empty.
  task automatic test_random_traffic(input int n_items, input int add_pct,
                                     input bit src_idle, input bit sink_idle);
    logic [MW-1:0] cmd;
    int            pick;
    src_gaps  = src_idle;
    sink_gaps = sink_idle;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        cmd = smpq_pkg::CMD_ADD;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) cmd = CMD_NOP;
        else if (pick < 7) cmd = smpq_pkg::CMD_PEEK;
        else cmd = smpq_pkg::CMD_POP;
      end
      issue_request(cmd, pick_key());
    end
  endtask

  // The sink holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_off = HOLD_CYCLES;
    for (int i = 0; i < 32; i++) begin
      issue_request((i % 4 == 3) ? smpq_pkg::CMD_POP : smpq_pkg::CMD_ADD, pick_key());
    end
    src_gaps = 1'b1;
  endtask

  initial begin : main
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_key_ordering();
    test_full_queue();
    test_random_traffic(150, 30, 1'b1, 1'b1);
    test_random_traffic(150, 70, 1'b1, 1'b1);
    test_random_traffic(150, 55, 1'b0, 1'b0);
    test_backpressure();
    test_random_traffic(150, 85, 1'b1, 1'b0);
    test_random_traffic(150, 20, 1'b0, 1'b1);
    test_random_traffic(120, 50, 1'b1, 1'b1);
    s_tvalid <= 1'b0;

    // Wait for every outstanding result, then a drain period for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d adds (%0d on a full queue), %0d pops, %0d peeks, %0d no-ops",
             n_add, n_full, n_pop, n_peek, n_nop);
    $display("Results checked: %0d, %0d on an empty queue, deepest fill %0d of %0d",
             n_checked, n_empty, deepest, QUEUE_DEPTH);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
